// ===== rtl/core/gbp_pkg.sv =====
// Shared types and constants for the gshare predictor with target buffer.
package gbp_pkg;

  localparam int PC_W = 64;

  // Item function codes
  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_UPDATE  = 1'b1;

  // Two-bit saturating direction counter
  localparam logic [1:0] CNT_MAX       = 2'd3;
  localparam logic [1:0] CNT_MIN       = 2'd0;
  localparam logic [1:0] CNT_TAKEN_MIN = 2'd2;

  // Fall-through step
  localparam logic [PC_W-1:0] PC_STEP = 64'd4;

  // One target buffer entry, as stored in the buffer RAM
  typedef struct packed {
    logic            valid;
    logic            conditional;
    logic [PC_W-1:0] tag;
    logic [PC_W-1:0] target;
  } btb_entry_t;

endpackage

// ===== rtl/core/gbp_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
module gbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/gshare_branch_predictor_btb.sv =====
// Gshare direction predictor with a direct-mapped branch target buffer.
//
// Input channel (in_valid / in_stall) carries one item per transfer: func
// selects predict or update, pc is the fetch or branch address, and
// is_conditional, taken and resolved_target describe a resolved branch on
// updates. Output channel (out_valid / out_stall) returns exactly one
// predicted_pc per item, in order; updates return zero.
// The transfer cycle issues the reads of the counter RAM and the target buffer
// RAM; the next cycle evaluates the hit, writes the RAMs back on updates and
// loads the output register when it is free. No new item is taken while one
// is being evaluated.
// The output register lets the next item enter while a result waits; if the
// receiver keeps stalling, one further result is parked and in_stall stays
// high until the output register frees.
// After reset a clearing pass writes zero to every entry of both RAMs, with
// in_stall held high. TARGET_ENTRIES must be a power of two.
module gshare_branch_predictor_btb #(
  parameter int HISTORY_BITS   = 8,
  parameter int TARGET_ENTRIES = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     func,
  input  logic [gbp_pkg::PC_W-1:0] pc,
  input  logic                     is_conditional,
  input  logic                     taken,
  input  logic [gbp_pkg::PC_W-1:0] resolved_target,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [gbp_pkg::PC_W-1:0] predicted_pc
);

  localparam int CNT_DEPTH  = 1 << HISTORY_BITS;
  localparam int BI_W       = $clog2(TARGET_ENTRIES);
  localparam int SWEEP      = (TARGET_ENTRIES > CNT_DEPTH) ? TARGET_ENTRIES : CNT_DEPTH;
  localparam int SW_W       = $clog2(SWEEP);
  localparam int ENTRY_W    = $bits(gbp_pkg::btb_entry_t);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_WAIT} state_t;

  state_t                   state;
  logic [SW_W-1:0]          sweep;
  logic [HISTORY_BITS-1:0]  history;
  logic [HISTORY_BITS-1:0]  history_next;

  // Latched item
  logic                     is_upd;
  logic [gbp_pkg::PC_W-1:0] pc_q;
  logic                     cond_q;
  logic                     taken_q;
  logic [gbp_pkg::PC_W-1:0] tgt_q;
  logic [BI_W-1:0]          bidx_q;
  logic [HISTORY_BITS-1:0]  cidx_q;
  logic [gbp_pkg::PC_W-1:0] res;

  logic                     accept;
  logic                     out_free;
  logic                     out_load;
  logic [BI_W-1:0]          bidx_in;
  logic [HISTORY_BITS-1:0]  cidx_in;

  // RAM ports
  logic                     btb_we;
  logic [BI_W-1:0]          btb_waddr;
  gbp_pkg::btb_entry_t      btb_wdata;
  logic [ENTRY_W-1:0]       btb_rdata;
  gbp_pkg::btb_entry_t      entry;
  logic                     cnt_we;
  logic [HISTORY_BITS-1:0]  cnt_waddr;
  logic [1:0]               cnt_wdata;
  logic [1:0]               cnt;
  logic [1:0]               cnt_next;

  logic                     hit;
  logic                     install;
  logic [gbp_pkg::PC_W-1:0] result;

  // Handshake
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = ((state == S_LOOK) || (state == S_WAIT)) && out_free;

  // Read indexes from the incoming item
  assign bidx_in = pc[BI_W+1:2];
  assign cidx_in = pc[HISTORY_BITS+1:2] ^ history;

  assign entry = gbp_pkg::btb_entry_t'(btb_rdata);

  // Saturating counter step
  always_comb begin
    if (taken_q) begin
      cnt_next = (cnt == gbp_pkg::CNT_MAX) ? cnt : cnt + 2'd1;
    end else begin
      cnt_next = (cnt == gbp_pkg::CNT_MIN) ? cnt : cnt - 2'd1;
    end
  end

  // Lookup result and buffer install decision
  assign hit     = entry.valid && (entry.tag == pc_q) &&
                   (!entry.conditional || (cnt >= gbp_pkg::CNT_TAKEN_MIN));
  assign install = taken_q && (!entry.valid || (entry.target != tgt_q));
  assign result  = (is_upd == gbp_pkg::FUNC_UPDATE) ? '0 :
                   (hit ? entry.target : pc_q + gbp_pkg::PC_STEP);

  assign history_next = HISTORY_BITS'({history, taken_q});

  // Write-back muxing: clearing pass or update
  always_comb begin
    if (state == S_CLEAR) begin
      btb_we    = 1'b1;
      btb_waddr = sweep[BI_W-1:0];
      btb_wdata = '0;
      cnt_we    = 1'b1;
      cnt_waddr = sweep[HISTORY_BITS-1:0];
      cnt_wdata = '0;
    end else begin
      btb_we                = (state == S_LOOK) && (is_upd == gbp_pkg::FUNC_UPDATE) && install;
      btb_waddr             = bidx_q;
      btb_wdata.valid       = 1'b1;
      btb_wdata.conditional = cond_q;
      btb_wdata.tag         = pc_q;
      btb_wdata.target      = tgt_q;
      cnt_we                = (state == S_LOOK) && (is_upd == gbp_pkg::FUNC_UPDATE) &&
                              entry.conditional;
      cnt_waddr             = cidx_q;
      cnt_wdata             = cnt_next;
    end
  end

  gbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TARGET_ENTRIES)
  ) u_btb_ram (
    .clk   (clk),
    .we    (btb_we),
    .waddr (btb_waddr),
    .wdata (btb_wdata),
    .re    (accept),
    .raddr (bidx_in),
    .rdata (btb_rdata)
  );

  gbp_ram #(
    .WIDTH (2),
    .DEPTH (CNT_DEPTH)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (accept),
    .raddr (cidx_in),
    .rdata (cnt)
  );

  // Control state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      sweep     <= '0;
      history   <= '0;
      out_valid <= 1'b0;
    end else begin
      // holds while stalled, drops after a transfer unless reloaded
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == SW_W'(SWEEP - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            is_upd  <= func;
            pc_q    <= pc;
            cond_q  <= is_conditional;
            taken_q <= taken;
            tgt_q   <= resolved_target;
            bidx_q  <= bidx_in;
            cidx_q  <= cidx_in;
            state   <= S_LOOK;
          end
        end
        S_LOOK: begin
          if ((is_upd == gbp_pkg::FUNC_UPDATE) && cond_q) begin
            history <= history_next;
          end
          res <= result;
          if (out_free) begin
            predicted_pc <= result;
            state        <= S_IDLE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (out_free) begin
            predicted_pc <= res;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // No item enters during the clearing pass
  assert property (@(posedge clk) disable iff (rst) (state == S_CLEAR) |-> in_stall)
    else $error("item accepted during clearing pass");

  // An accepted item is evaluated in the following cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> (state == S_LOOK))
    else $error("accepted item not evaluated");

  // A parked result only exists while the output register is occupied
  assert property (@(posedge clk) disable iff (rst) (state == S_WAIT) |-> out_valid)
    else $error("parked result with empty output register");

  // RAM write-back only happens in the clearing pass or the evaluate cycle
  assert property (@(posedge clk) disable iff (rst)
                   (btb_we || cnt_we) |-> ((state == S_CLEAR) || (state == S_LOOK)))
    else $error("RAM write outside clear or evaluate cycle");

endmodule
